[rtl/core/bcc_pkg.sv]
// Package for the button click classifier: widths, time type, gesture codes,
// register map and reset values. No dependencies.
package bcc_pkg;

	// Timestamp arithmetic width (16..64); now_ms is truncated or zero-extended to it.
	localparam int TIME_BITS = 32;
	localparam int NOW_W     = 32;
	localparam int CFG_W     = 16;
	localparam int GESTURE_W = 3;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CFG_W-1:0]     cfg_val_t;

	typedef enum logic [GESTURE_W-1:0] {
		G_NONE   = 3'd0,
		G_SINGLE = 3'd1,
		G_DOUBLE = 3'd2,
		G_TRIPLE = 3'd3,
		G_LONG   = 3'd4
	} gesture_t;

	// register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LONG     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAP      = 2'd2;

	localparam cfg_val_t DEBOUNCE_RST = 16'd50;
	localparam cfg_val_t LONG_RST     = 16'd1000;
	localparam cfg_val_t GAP_RST      = 16'd300;

	typedef struct packed {
		cfg_val_t debounce_ms;
		cfg_val_t long_press_ms;
		cfg_val_t click_gap_ms;
	} cfg_t;

endpackage

[rtl/core/bcc_if.sv]
// Channel interfaces for the button click classifier: pin samples in, gestures out.
// Depends on bcc_pkg.
interface bcc_in_if import bcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             raw_level;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, raw_level, now_ms, input ready);
	modport sink   (input valid, raw_level, now_ms, output ready);
endinterface

interface bcc_out_if import bcc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [GESTURE_W-1:0] gesture;

	modport source (output valid, gesture, input ready);
	modport sink   (input valid, gesture, output ready);
endinterface

[rtl/core/bcc_cfg_regs.sv]
// APB-style configuration registers of the button click classifier.
// Depends on bcc_pkg.
module bcc_cfg_regs import bcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_RST;
			cfg_q.click_gap_ms  <= GAP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE: cfg_q.debounce_ms   <= pwdata[CFG_W-1:0];
				REG_LONG:     cfg_q.long_press_ms <= pwdata[CFG_W-1:0];
				REG_GAP:      cfg_q.click_gap_ms  <= pwdata[CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEBOUNCE: prdata = PDATA_W'(cfg_q.debounce_ms);
			REG_LONG:     prdata = PDATA_W'(cfg_q.long_press_ms);
			REG_GAP:      prdata = PDATA_W'(cfg_q.click_gap_ms);
			default:      prdata = '0;
		endcase
	end

endmodule

[rtl/core/bcc_track.sv]
// Debounce, press/release timing and click counting for one sample per cycle while step is high.
// Holds the tracking state; depends on bcc_pkg.
module bcc_track import bcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  logic     level,
	input  time_t    now,
	input  cfg_t     cfg,
	output gesture_t gesture
);

	logic       prev_raw_q, stable_q, long_rep_q;
	logic [1:0] count_q;
	time_t      deb_start_q, press_q, release_q;

	time_t      deb_start_n, press_n, release_n;
	logic       settle, press_ev, release_ev;
	logic       stable_n, long_rep_a, long_hit, gap_hit;
	logic [1:0] count_a, count_b, count_n;

	always_comb begin
		// raw change restarts debounce
		deb_start_n = (level != prev_raw_q) ? now : deb_start_q;
		settle      = ((now - deb_start_n) > TIME_BITS'(cfg.debounce_ms)) &&
		              (level != stable_q);
		press_ev    = settle && !level;
		release_ev  = settle && level;
		stable_n    = settle ? level : stable_q;
		press_n     = press_ev ? now : press_q;
		release_n   = release_ev ? now : release_q;
		long_rep_a  = press_ev ? 1'b0 : long_rep_q;
		count_a     = (release_ev && !long_rep_q && count_q != 2'd3) ?
		              count_q + 2'd1 : count_q;

		long_hit = !stable_n && !long_rep_a &&
		           ((now - press_n) > TIME_BITS'(cfg.long_press_ms));
		count_b  = long_hit ? 2'd0 : count_a;

		gap_hit = (count_b != 2'd0) &&
		          ((now - release_n) > TIME_BITS'(cfg.click_gap_ms));
		count_n = gap_hit ? 2'd0 : count_b;

		gesture = G_NONE;
		if (gap_hit) begin
			case (count_b)
				2'd1:    gesture = G_SINGLE;
				2'd2:    gesture = G_DOUBLE;
				default: gesture = G_TRIPLE;
			endcase
		end else if (long_hit) begin
			gesture = G_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q  <= 1'b1;
			stable_q    <= 1'b1;
			deb_start_q <= '0;
			press_q     <= '0;
			release_q   <= '0;
			count_q     <= 2'd0;
			long_rep_q  <= 1'b0;
		end else if (step) begin
			prev_raw_q  <= level;
			stable_q    <= stable_n;
			deb_start_q <= deb_start_n;
			press_q     <= press_n;
			release_q   <= release_n;
			count_q     <= count_n;
			long_rep_q  <= long_rep_a | long_hit;
		end
	end

endmodule

[rtl/core/button_click_classifier.sv]
// Top level of the button click classifier: input stage, tracker, result register.
// Depends on bcc_pkg, bcc_if, bcc_cfg_regs and bcc_track.
//
// Takes one poll of an active-low button (raw pin level plus a free-running
// millisecond timestamp) per beat and returns exactly one gesture beat for
// each: none, single, double, triple (three or more clicks) or long press.
// A poll is taken every clock when the result side keeps up. Each beat
// passes through the input register and then moves into the result
// register, which holds it until the result side takes it. The tracker
// update folds each poll into the debounce, press/release and click-count
// state combinationally, so the block takes a new poll while the previous
// one moves into the result register.
// All elapsed times are modular differences at TIME_BITS width and use a
// strict greater-than against the 16-bit thresholds. Thresholds are written
// through the APB-style port at byte addresses 0, 4 and 8 (debounce, long
// press, click gap; reset 50, 1000, 300 ms); write them only while idle.
module button_click_classifier import bcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	bcc_in_if.sink             sample,
	bcc_out_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t     cfg;
	logic     valid_s1, level_s1;
	time_t    now_s1;
	logic     advance;
	gesture_t gesture_c;
	logic     out_valid_q;
	gesture_t gesture_q;

	bcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 moves on whenever the result register is free or being drained
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			level_s1 <= sample.raw_level;
			now_s1   <= TIME_BITS'(sample.now_ms);
		end
	end

	bcc_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.level   (level_s1),
		.now     (now_s1),
		.cfg     (cfg),
		.gesture (gesture_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_q <= gesture_c;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.gesture = gesture_q;

endmodule

[rtl/core/bcc_checker.sv]
// Port-level checks for the button click classifier, bound to the top level.
// Depends on bcc_pkg.
module bcc_checker import bcc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_valid,
	input logic                 sample_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input logic [GESTURE_W-1:0] result_gesture
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	a_hold_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_gesture))
		else $error("result gesture changed while stalled");

	// a fresh result needs a poll that was accepted and passed through the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("result beat without a matching poll");

	// input backpressure only comes from a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("poll refused while result side is free");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.sample_valid   (sample.valid),
	.sample_ready   (sample.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_gesture (result.gesture)
);
